/* src/assert_macros.svh */
// Assertion macros shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define RFCT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RFCT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/rfct_pkg.sv */
// Constants and codes for the remote flag completion tracker.
`timescale 1ns / 1ps

package rfct_pkg;

    localparam int FLAG_SLOTS_DEF = 1024;
    localparam int MAX_RANKS      = 16;
    // Width of enqueue index arithmetic: tile * group_size + start + span.
    localparam int PW             = 17;

    localparam logic [10:0] COUNT_MAX   = 11'd2047;
    localparam logic [7:0]  FLAG_RAISED = 8'd1;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_CHECK   = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DONE   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_IGNORE = 2'd3;

    localparam logic REG_LOCAL_RANK = 1'b0;
    localparam logic REG_GROUP_SIZE = 1'b1;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 88;

endpackage

/* src/remote_flag_completion_tracker.sv */
// Remote flag completion tracker: scoreboard of operations awaiting peer flags.
//
//  channel  | direction | moves
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | enqueue or check item, kind in tuser
//  m_axis   | out       | one result per item, status in tuser
//  APB      | in/out    | local_rank (0x0), group_size (0x4)
//
// After reset a clearing pass runs over every slot of the flag and count
// memories; s_axis_tready stays low meanwhile. Items are taken one at a time.
// A check takes one divide in the shared divider (one quotient bit per cycle);
// an ignored check and a rejected enqueue go straight to the result. An enqueue
// takes one divide, or two and a read-modify-write of the count memory when the
// local flag falls in the span. A stalled m_axis holds the next result in the
// sequencer; the following item is taken once it is handed over.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module remote_flag_completion_tracker #(
    parameter int FLAG_SLOTS = rfct_pkg::FLAG_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // task_id[63:0], rank_span[68:64], rank_start[72:69], tile_number[82:73],
    // flag_slot[92:83], flag_byte[100:93], zero[103:101]
    input  logic [rfct_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // opcode[0]
    input  logic [0:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // finished_task[63:0], pending_ops[74:64], slot_limit[85:75], zero[87:86]
    output logic [rfct_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]                     m_axis_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import rfct_pkg::*;

    localparam int AW = $clog2(FLAG_SLOTS);
    localparam int LW = AW + 1;
    localparam int CW = $clog2(AW + 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ENQ_CHK,
        S_ENQ_DIV,
        S_ENQ_WR,
        S_LOC_DIV,
        S_LOC_RD,
        S_LOC_WR,
        S_CHK_DIV,
        S_CHK_RD,
        S_CHK_WR,
        S_RESULT
    } t_state;

    // ---------------- configuration registers ----------------
    logic [3:0] r_local_rank;
    logic [4:0] r_group_size;
    logic       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_rank <= 4'd0;
            r_group_size <= 5'd2;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_LOCAL_RANK: r_local_rank <= pwdata[3:0];
                REG_GROUP_SIZE: r_group_size <= pwdata[4:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LOCAL_RANK: prdata = 32'(r_local_rank);
            REG_GROUP_SIZE: prdata = 32'(r_group_size);
        endcase
    end

    // ---------------- input fields ----------------
    logic        w_opcode;
    logic [63:0] w_task_id;
    logic [4:0]  w_rank_span;
    logic [3:0]  w_rank_start;
    logic [9:0]  w_tile_number;
    logic [9:0]  w_flag_slot;
    logic [7:0]  w_flag_byte;

    assign w_opcode      = s_axis_tuser[0];
    assign w_task_id     = s_axis_tdata[63:0];
    assign w_rank_span   = s_axis_tdata[68:64];
    assign w_rank_start  = s_axis_tdata[72:69];
    assign w_tile_number = s_axis_tdata[82:73];
    assign w_flag_slot   = s_axis_tdata[92:83];
    assign w_flag_byte   = s_axis_tdata[100:93];

    // ---------------- state ----------------
    t_state          r_state;
    logic [AW-1:0]   r_clr_cnt;
    logic [LW-1:0]   r_used;
    logic [10:0]     r_open;
    logic [4:0]      r_recent;

    logic [63:0]     r_task;
    logic [4:0]      r_span;
    logic [3:0]      r_start;
    logic [PW-1:0]   r_base;
    logic [AW-1:0]   r_slot;
    logic [7:0]      r_byte;
    logic [AW-1:0]   r_local_idx;
    logic [LW-1:0]   r_last_p1;
    logic            r_in_span;

    logic [AW-1:0]   r_div_q;
    logic [4:0]      r_div_rem;
    logic [4:0]      r_div_den;
    logic [CW-1:0]   r_div_cnt;

    logic [1:0]      r_res_status;
    logic [63:0]     r_res_task;

    logic            r_out_valid;
    logic [1:0]      r_out_status;
    logic [63:0]     r_out_task;
    logic [10:0]     r_out_pend;
    logic [10:0]     r_out_limit;

    // ---------------- memories ----------------
    logic            mem_done [FLAG_SLOTS];
    logic [4:0]      mem_rem  [FLAG_SLOTS];
    logic [63:0]     mem_task [FLAG_SLOTS];

    logic            w_done_we;
    logic [AW-1:0]   w_done_addr;
    logic            w_done_wd;
    logic            w_rem_we;
    logic [AW-1:0]   w_rem_addr;
    logic [4:0]      w_rem_wd;
    logic            w_task_we;
    logic [AW-1:0]   w_task_addr;
    logic            r_done_q;
    logic [4:0]      r_rem_q;
    logic [63:0]     r_task_q;

    always_ff @(posedge i_clk) begin
        if (w_done_we) mem_done[w_done_addr] <= w_done_wd;
        r_done_q <= mem_done[w_done_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_rem_we) mem_rem[w_rem_addr] <= w_rem_wd;
        r_rem_q <= mem_rem[w_rem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_task_we) mem_task[w_task_addr] <= r_task;
        r_task_q <= mem_task[w_task_addr];
    end

    // ---------------- shared restoring divider, one quotient bit a cycle ----
    logic [5:0]    n_div_trial;
    logic          w_div_ge;
    logic [4:0]    n_div_rem;
    logic [AW-1:0] n_div_q;

    assign n_div_trial = {r_div_rem, r_div_q[AW-1]};
    assign w_div_ge    = n_div_trial >= {1'b0, r_div_den};
    assign n_div_rem   = w_div_ge ? 5'(n_div_trial - {1'b0, r_div_den}) : n_div_trial[4:0];
    assign n_div_q     = {r_div_q[AW-2:0], w_div_ge};

    // ---------------- item checks ----------------
    logic [PW-1:0] w_slot_ext;
    logic          w_ignore;
    logic [PW-1:0] w_first;
    logic [PW-1:0] w_last;
    logic [PW-1:0] w_local;
    logic          w_reject;
    logic          w_hit;

    assign w_slot_ext = PW'(w_flag_slot);
    assign w_ignore   = (r_open == '0) || (r_recent == '0)
                     || (w_slot_ext >= PW'(r_used))
                     || (w_slot_ext >= PW'(FLAG_SLOTS));

    assign w_first  = r_base + PW'(r_start);
    assign w_last   = w_first + PW'(r_span) - PW'(1);
    assign w_local  = r_base + PW'(r_local_rank);
    // tile_number is 10 bits wide, so the tile limit can never be exceeded
    assign w_reject = (r_span == '0)
                   || ((PW'(r_start) + PW'(r_span)) > PW'(MAX_RANKS))
                   || (w_last >= PW'(FLAG_SLOTS));

    assign w_hit = !r_done_q && (r_byte == FLAG_RAISED) && (r_rem_q != '0);

    // ---------------- memory port control ----------------
    always_comb begin
        w_done_we   = 1'b0;
        w_done_addr = r_slot;
        w_done_wd   = 1'b1;
        w_rem_we    = 1'b0;
        w_rem_addr  = r_div_q;
        w_rem_wd    = r_rem_q - 5'd1;
        w_task_we   = 1'b0;
        w_task_addr = r_div_q;
        case (r_state)
            S_CLEAR: begin
                w_done_we   = 1'b1;
                w_done_addr = r_clr_cnt;
                w_done_wd   = 1'b0;
                w_rem_we    = 1'b1;
                w_rem_addr  = r_clr_cnt;
                w_rem_wd    = 5'd0;
            end
            S_ENQ_WR: begin
                w_rem_we  = 1'b1;
                w_rem_wd  = r_span;
                w_task_we = 1'b1;
            end
            S_LOC_WR: begin
                w_done_we   = 1'b1;
                w_done_addr = r_local_idx;
                w_rem_we    = (r_rem_q != '0);
            end
            S_CHK_WR: begin
                w_done_we = w_hit;
                w_rem_we  = w_hit;
            end
            default: begin
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_used      <= '0;
            r_open      <= '0;
            r_recent    <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in S_RESULT the output register is handled below
            if (r_out_valid && m_axis_tready && (r_state != S_RESULT)) r_out_valid <= 1'b0;

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + AW'(1);
                    if (r_clr_cnt == AW'(FLAG_SLOTS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_task     <= w_task_id;
                        r_span     <= w_rank_span;
                        r_start    <= w_rank_start;
                        r_base     <= PW'(w_tile_number) * PW'(r_group_size);
                        r_slot     <= w_slot_ext[AW-1:0];
                        r_byte     <= w_flag_byte;
                        r_res_task <= '0;
                        if (w_opcode == OP_ENQUEUE) begin
                            r_state <= S_ENQ_CHK;
                        end else if (w_ignore) begin
                            r_res_status <= ST_IGNORE;
                            r_state      <= S_RESULT;
                        end else begin
                            r_div_q   <= w_slot_ext[AW-1:0];
                            r_div_rem <= '0;
                            r_div_den <= r_recent;
                            r_div_cnt <= CW'(AW);
                            r_state   <= S_CHK_DIV;
                        end
                    end
                end
                S_ENQ_CHK: begin
                    r_last_p1   <= LW'(w_last + PW'(1));
                    r_local_idx <= w_local[AW-1:0];
                    r_in_span   <= (w_local >= w_first) && (w_local <= w_last);
                    if (w_reject) begin
                        r_res_status <= ST_REJECT;
                        r_state      <= S_RESULT;
                    end else begin
                        r_div_q   <= w_first[AW-1:0];
                        r_div_rem <= '0;
                        r_div_den <= r_span;
                        r_div_cnt <= CW'(AW);
                        r_state   <= S_ENQ_DIV;
                    end
                end
                S_ENQ_DIV, S_LOC_DIV, S_CHK_DIV: begin
                    r_div_q   <= n_div_q;
                    r_div_rem <= n_div_rem;
                    r_div_cnt <= r_div_cnt - CW'(1);
                    if (r_div_cnt == CW'(1)) begin
                        case (r_state)
                            S_ENQ_DIV: r_state <= S_ENQ_WR;
                            S_LOC_DIV: r_state <= S_LOC_RD;
                            default:   r_state <= S_CHK_RD;
                        endcase
                    end
                end
                S_ENQ_WR: begin
                    // task and count are written by the memory port this cycle
                    if (r_used < r_last_p1) r_used <= r_last_p1;
                    r_recent <= r_span;
                    if (r_open < COUNT_MAX) r_open <= r_open + 11'd1;
                    if (r_in_span) begin
                        // local flag is charged to slot local / span
                        r_div_q   <= r_local_idx;
                        r_div_rem <= '0;
                        r_div_cnt <= CW'(AW);
                        r_state   <= S_LOC_DIV;
                    end else begin
                        r_res_status <= ST_OK;
                        r_state      <= S_RESULT;
                    end
                end
                S_LOC_RD: begin
                    r_state <= S_LOC_WR;
                end
                S_LOC_WR: begin
                    r_res_status <= ST_OK;
                    r_state      <= S_RESULT;
                end
                S_CHK_RD: begin
                    r_state <= S_CHK_WR;
                end
                S_CHK_WR: begin
                    if (w_hit && (r_rem_q == 5'd1)) begin
                        r_res_status <= ST_DONE;
                        r_res_task   <= r_task_q;
                        if (r_open != '0) r_open <= r_open - 11'd1;
                    end else begin
                        r_res_status <= ST_OK;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_task   <= r_res_task;
                        r_out_pend   <= r_open;
                        r_out_limit  <= 11'(r_used);
                        r_state      <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {2'b00, r_out_limit, r_out_pend, r_out_task};

    // ---------------- assertions ----------------
    `RFCT_ASSERT_ALWAYS(a_clear_blocks_input, (r_state == S_CLEAR) |-> !s_axis_tready, "item taken during clearing pass")
    `RFCT_ASSERT(a_task_only_on_done, (m_axis_tvalid && (m_axis_tuser != ST_DONE)) |-> (m_axis_tdata[63:0] == 64'd0), "task id on a result that is not a completion")
    `RFCT_ASSERT(a_div_count_live, ((r_state == S_ENQ_DIV) || (r_state == S_LOC_DIV) || (r_state == S_CHK_DIV)) |-> (r_div_cnt != '0), "divider ran past its last step")

endmodule
